/* rtl/ctmp_pkg.sv */
// Package: shared types and constants for the CSV telemetry message parser.
package ctmp_pkg;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;

  localparam logic [2:0] KIND_ERROR   = 3'd0;
  localparam logic [2:0] KIND_FREQ    = 3'd1;
  localparam logic [2:0] KIND_ID      = 3'd2;
  localparam logic [2:0] KIND_PROBE   = 3'd3;
  localparam logic [2:0] KIND_SUMMARY = 3'd4;

  typedef enum logic [2:0] {
    PH_LEAD    = 3'd0,
    PH_POS     = 3'd1,
    PH_NEG     = 3'd2,
    PH_DONE_P  = 3'd3,
    PH_DONE_N  = 3'd4
  } phase_t;

  typedef enum logic [1:0] {
    ST_PARSE = 2'd0,
    ST_EMIT  = 2'd1
  } state_t;

  typedef struct packed {
    logic       accept;
    logic       emit_load;
    logic       emit_next;
    logic       emit_done;
  } ctrl_cmd_t;

  typedef struct packed {
    logic       item_last;
    logic       run_last;
  } ctrl_sts_t;
endpackage

/* rtl/ctmp_ctrl.sv */
// Controller: sequences character parsing and the result run.
module ctmp_ctrl import ctmp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_PARSE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_PARSE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.item_last) begin
            cmd.emit_load = 1'b1;
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (sts.run_last) begin
            cmd.emit_done = 1'b1;
            state_nxt = ST_PARSE;
          end else begin
            cmd.emit_next = 1'b1;
          end
        end
      end
      default: state_nxt = ST_PARSE;
    endcase
  end
endmodule

/* rtl/ctmp_dp.sv */
// Datapath: field tokeniser, number conversion, stores and result formatting.
module ctmp_dp import ctmp_pkg::*; #(
  parameter int ID_LEN = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_wdata,
  input  logic               in_action,
  input  logic [7:0]         in_character,
  input  logic               in_last,
  input  ctrl_cmd_t          cmd,
  output ctrl_sts_t          sts,
  output logic [2:0]         out_record_kind,
  output logic [31:0]        out_value,
  output logic [1:0]         out_probe_index,
  output logic               out_attached,
  output logic signed [15:0] out_temp_tenths,
  output logic               out_alarm,
  output logic signed [15:0] out_limit_high,
  output logic signed [15:0] out_limit_low,
  output logic               out_fahrenheit,
  output logic               out_end_of_run
);
  localparam int IW = $clog2(ID_LEN);
  localparam int XW = (IW > 3) ? IW : 3;
  localparam int IDMAX = ID_LEN - 1;

  logic [2:0]  pcount_r;
  logic [4:0]  field_r;
  logic        open_r;
  logic [16:0] acc_r;
  phase_t      phase_r;
  logic [7:0]  id_mem [IDMAX];
  logic [IW-1:0] id_len_r;
  logic [31:0] freq_r;
  logic        p_att_r [4];
  logic        p_alm_r [4];
  logic [15:0] p_tmp_r [4];
  logic [15:0] p_max_r [4];
  logic [15:0] p_min_r [4];
  logic [2:0]  flags_r;

  // emission
  logic        mode_r;       // 0 sync, 1 state
  logic        err_r;
  logic        in_id_r;
  logic [XW-1:0] idx_r;
  logic [7:0]  id_rd_r;

  logic        is_comma, is_digit, is_space, do_close;
  logic [3:0]  dval;
  logic [20:0] prod;
  logic [16:0] acc_nxt;
  phase_t      phase_nxt;
  logic [15:0] v;
  logic [2:0]  n;
  logic [4:0]  fend, pk;
  logic [1:0]  pidx;
  logic [4:0]  field_nxt;
  logic        e_mode, e_err, e_has_id;

  always_comb begin
    is_comma = in_character == CHAR_COMMA;
    is_digit = in_character >= CHAR_ZERO && in_character <= CHAR_NINE;
    is_space = in_character == CHAR_SPACE ||
               (in_character >= 8'd9 && in_character <= 8'd13);
    dval = 4'(in_character - CHAR_ZERO);
    prod = {acc_r, 3'b0} + {2'b0, acc_r, 1'b0} + 21'(dval);
    acc_nxt = acc_r;
    phase_nxt = phase_r;
    if (!is_comma) begin
      case (phase_r)
        PH_LEAD: begin
          if (!is_space) begin
            if (in_character == CHAR_PLUS) phase_nxt = PH_POS;
            else if (in_character == CHAR_MINUS) phase_nxt = PH_NEG;
            else if (is_digit) begin
              acc_nxt = 17'(dval);
              phase_nxt = PH_POS;
            end else phase_nxt = PH_DONE_P;
          end
        end
        PH_POS, PH_NEG: begin
          if (is_digit) acc_nxt = (prod > 21'd32768) ? 17'd32768 : prod[16:0];
          else phase_nxt = (phase_r == PH_POS) ? PH_DONE_P : PH_DONE_N;
        end
        default: ;
      endcase
    end
    if (phase_nxt == PH_NEG || phase_nxt == PH_DONE_N) v = 16'(-acc_nxt);
    else v = (acc_nxt > 17'd32767) ? 16'h7FFF : acc_nxt[15:0];
    n = (pcount_r == 3'd2 || pcount_r == 3'd4) ? pcount_r : 3'd0;
    fend = 5'd4 + 5'(n) * 5'd5;
    pk = field_r - 5'd4;
    pidx = (pk >= 5'd15) ? 2'd3 : (pk >= 5'd10) ? 2'd2 : (pk >= 5'd5) ? 2'd1 : 2'd0;
    do_close = cmd.accept && ((is_comma && open_r) || (in_last && (open_r || !is_comma)));
    field_nxt = (do_close && field_r != 5'd31) ? field_r + 5'd1 : field_r;
    e_mode = in_action;
    e_has_id = id_len_r != '0 ||
               (!is_comma && !in_action && field_r == 5'd1 && IDMAX > 0);
    if (!in_action) e_err = field_nxt < 5'd6;
    else e_err = n == 3'd0 || field_nxt < fend + 5'd2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcount_r <= 3'd4;
      field_r <= '0; open_r <= 1'b0; acc_r <= '0; phase_r <= PH_LEAD;
      id_len_r <= '0; freq_r <= '0; flags_r <= '0;
    end else begin
      if (cfg_we) pcount_r <= cfg_wdata;
      if (cmd.accept) begin
        if (do_close) begin
          if (!in_action) begin
            if (field_r >= 5'd2 && field_r <= 5'd5)
              freq_r <= freq_r | (32'(v[7:0]) << {field_r[1:0] - 2'd2, 3'b0});
          end else begin
            if (field_r == 5'd2) flags_r[0] <= v == 16'd1;
            else if (field_r == 5'd3) flags_r[1] <= v != 16'd0;
            else if (field_r >= 5'd4 && field_r < fend) begin
              case (pk)
                5'd0, 5'd5, 5'd10, 5'd15: p_att_r[pidx] <= v != 16'd3;
                5'd1, 5'd6, 5'd11, 5'd16: p_tmp_r[pidx] <= v;
                5'd2, 5'd7, 5'd12, 5'd17: p_alm_r[pidx] <= v != 16'd0;
                5'd3, 5'd8, 5'd13, 5'd18: p_max_r[pidx] <= v;
                default: p_min_r[pidx] <= v;
              endcase
            end else if (n != 3'd0 && field_r == fend) flags_r[2] <= v != 16'd0;
          end
        end
        if (do_close || in_last) begin
          open_r <= 1'b0; acc_r <= '0; phase_r <= PH_LEAD;
        end else if (!is_comma) begin
          open_r <= 1'b1; acc_r <= acc_nxt; phase_r <= phase_nxt;
        end
        field_r <= in_last ? 5'd0 : field_nxt;
        if (!is_comma && !in_action && field_r == 5'd1 && 32'(id_len_r) < IDMAX)
          id_len_r <= id_len_r + 1'b1;
      end
      if (cmd.emit_done) begin
        id_len_r <= '0; freq_r <= '0;
      end
    end
  end

  // store device id characters
  always_ff @(posedge clk) begin
    if (cmd.accept && !is_comma && !in_action && field_r == 5'd1 &&
        32'(id_len_r) < IDMAX)
      id_mem[id_len_r] <= in_character;
  end

  logic [XW-1:0] rd_idx;
  always_comb begin
    if (cmd.emit_load) rd_idx = '0;
    else if (cmd.emit_next) rd_idx = idx_r + 1'b1;
    else rd_idx = idx_r;
  end
  always_ff @(posedge clk) begin
    if (32'(rd_idx) < IDMAX) id_rd_r <= id_mem[rd_idx[IW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_load) begin
      mode_r <= e_mode; err_r <= e_err; in_id_r <= e_has_id; idx_r <= '0;
    end else if (cmd.emit_next) begin
      idx_r <= idx_r + 1'b1;
      if (mode_r == 1'b0 && in_id_r && idx_r + 1'b1 == XW'(id_len_r)) in_id_r <= 1'b0;
    end
  end

  logic [1:0] pi;
  always_comb begin
    pi = idx_r[1:0];
    out_record_kind = KIND_ERROR; out_value = '0; out_probe_index = '0;
    out_attached = 1'b0; out_temp_tenths = '0; out_alarm = 1'b0;
    out_limit_high = '0; out_limit_low = '0; out_fahrenheit = 1'b0;
    sts.run_last = 1'b1;
    if (!err_r) begin
      if (!mode_r) begin
        if (in_id_r) begin
          out_record_kind = KIND_ID; out_value = 32'(id_rd_r); sts.run_last = 1'b0;
        end else begin
          out_record_kind = KIND_FREQ; out_value = freq_r;
        end
      end else if (32'(idx_r) < 32'(n)) begin
        out_record_kind = KIND_PROBE; out_probe_index = pi;
        out_attached = p_att_r[pi]; out_temp_tenths = p_tmp_r[pi];
        out_alarm = p_alm_r[pi]; out_limit_high = p_max_r[pi];
        out_limit_low = p_min_r[pi]; sts.run_last = 1'b0;
      end else begin
        out_record_kind = KIND_SUMMARY; out_attached = flags_r[2];
        out_alarm = flags_r[1]; out_fahrenheit = flags_r[0];
      end
    end
    out_end_of_run = sts.run_last;
    sts.item_last = in_last;
  end
endmodule

/* rtl/csv_telemetry_message_parser.sv */
// Top level: CSV telemetry message parser.
// Throughput: one character transfer per cycle while parsing.
// Latency: the first record is offered in the cycle after the last character
// transfer; records then follow at one per cycle while out_ready is high.
// No character is taken during the run. Reset: synchronous, active low;
// it clears control state and summary flags and sets probe_count to 4.
module csv_telemetry_message_parser import ctmp_pkg::*; #(
  parameter int ID_LEN = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_wdata,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               in_action,
  input  logic [7:0]         in_character,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_record_kind,
  output logic [31:0]        out_value,
  output logic [1:0]         out_probe_index,
  output logic               out_attached,
  output logic signed [15:0] out_temp_tenths,
  output logic               out_alarm,
  output logic signed [15:0] out_limit_high,
  output logic signed [15:0] out_limit_low,
  output logic               out_fahrenheit,
  output logic               out_end_of_run
);
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  ctmp_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .sts, .cmd);

  ctmp_dp #(.ID_LEN(ID_LEN)) u_dp (.clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_action, .in_character, .in_last, .cmd, .sts,
    .out_record_kind, .out_value, .out_probe_index, .out_attached,
    .out_temp_tenths, .out_alarm, .out_limit_high, .out_limit_low,
    .out_fahrenheit, .out_end_of_run);

  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output both open");
  a_lastrun: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_last) |=> out_valid) else $error("no run");
  a_err: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_record_kind == KIND_ERROR) |-> out_end_of_run)
    else $error("error record not last");
endmodule

/* tb/csv_telemetry_message_parser_tb.sv */
// Testbench: directed and random CSV messages checked against a behavioural parser model.
`timescale 1ns / 1ps
module csv_telemetry_message_parser_tb;
  import ctmp_pkg::*;

  localparam int IDL = 32;

  typedef struct {
    logic [2:0]         kind;
    logic [31:0]        value;
    logic [1:0]         idx;
    logic               att;
    logic signed [15:0] temp;
    logic               alarm;
    logic signed [15:0] tmax;
    logic signed [15:0] tmin;
    logic               fahr;
    logic               eor;
  } rec_t;

  typedef struct {
    logic               att;
    logic signed [15:0] temp;
    logic               alarm;
    logic signed [15:0] tmax;
    logic signed [15:0] tmin;
  } probe_t;

  logic clk = 0, rst_n = 0;
  logic cfg_we = 0;
  logic [2:0] cfg_wdata = 0;
  logic in_valid = 0, in_action = 0, in_last = 0;
  logic [7:0] in_character = 8'h41;
  logic in_ready, out_valid;
  logic out_ready = 0;
  logic [2:0] out_record_kind;
  logic [31:0] out_value;
  logic [1:0] out_probe_index;
  logic out_attached, out_alarm, out_fahrenheit, out_end_of_run;
  logic signed [15:0] out_temp_tenths, out_limit_high, out_limit_low;

  csv_telemetry_message_parser #(.ID_LEN(IDL)) dut (.*);

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  // parser model state
  logic [2:0]  m_probes;
  int          m_field, m_accum, m_idlen;
  logic        m_open;
  phase_t      m_phase;
  logic [7:0]  m_idbuf [IDL];
  logic [31:0] m_freq;
  probe_t      m_store [4];
  logic        m_fahr, m_nalarm, m_blower;

  rec_t expected_q[$];
  bit   failed = 0;
  bit   typed_err = 0;
  bit   hold_now = 0;
  int   items_sent = 0;

  function automatic int probes_used();
    return (m_probes == 2 || m_probes == 4) ? int'(m_probes) : 0;
  endfunction

  function automatic int field_value();
    if (m_phase == PH_NEG || m_phase == PH_DONE_N) return -m_accum;
    return (m_accum > 32767) ? 32767 : m_accum;
  endfunction

  function automatic void close_field(logic act);
    int k, v, n, p;
    k = m_field;
    v = field_value();
    n = probes_used();
    if (!act) begin
      if (k >= 2 && k <= 5) m_freq |= (32'(v) & 32'hFF) << (8 * (k - 2));
    end else if (k == 2) begin
      m_fahr = (v == 1);
    end else if (k == 3) begin
      m_nalarm = (v != 0);
    end else if (k >= 4 && k < 4 + 5 * n) begin
      p = (k - 4) / 5;
      case ((k - 4) % 5)
        0: m_store[p].att = (v != 3);
        1: m_store[p].temp = 16'(v);
        2: m_store[p].alarm = (v != 0);
        3: m_store[p].tmax = 16'(v);
        default: m_store[p].tmin = 16'(v);
      endcase
    end else if (n != 0 && k == 4 + 5 * n) begin
      m_blower = (v != 0);
    end
    if (m_field < 31) m_field++;
    m_open = 0;
    m_accum = 0;
    m_phase = PH_LEAD;
  endfunction

  function automatic void parse_char(logic [7:0] c);
    bit dig;
    dig = (c >= CHAR_ZERO && c <= CHAR_NINE);
    case (m_phase)
      PH_LEAD: begin
        if (c == CHAR_SPACE || (c >= 8'd9 && c <= 8'd13)) ;
        else if (c == CHAR_PLUS) m_phase = PH_POS;
        else if (c == CHAR_MINUS) m_phase = PH_NEG;
        else if (dig) begin
          m_accum = int'(c - CHAR_ZERO);
          m_phase = PH_POS;
        end else m_phase = PH_DONE_P;
      end
      PH_POS, PH_NEG: begin
        if (dig) begin
          m_accum = m_accum * 10 + int'(c - CHAR_ZERO);
          if (m_accum > 32768) m_accum = 32768;
        end else m_phase = (m_phase == PH_POS) ? PH_DONE_P : PH_DONE_N;
      end
      default: ;
    endcase
  endfunction

  function automatic rec_t blank_rec(logic [2:0] kind);
    rec_t r;
    r = '{default: '0};
    r.kind = kind;
    return r;
  endfunction

  function automatic void reset_message();
    m_field = 0;
    m_open = 0;
    m_accum = 0;
    m_phase = PH_LEAD;
    m_idlen = 0;
    m_freq = 0;
  endfunction

  task automatic predict_records(input logic act, input logic [7:0] c, input logic lst,
                                 output rec_t recs[$]);
    rec_t r;
    int n;
    recs = {};
    if (c == CHAR_COMMA) begin
      if (m_open) close_field(act);
    end else begin
      m_open = 1;
      parse_char(c);
      if (!act && m_field == 1 && m_idlen < IDL - 1) begin
        m_idbuf[m_idlen] = c;
        m_idlen++;
      end
    end
    if (!lst) return;
    if (m_open) close_field(act);
    n = probes_used();
    if (!act && m_field >= 6) begin
      for (int i = 0; i < m_idlen; i++) begin
        r = blank_rec(KIND_ID);
        r.value = {24'd0, m_idbuf[i]};
        recs.push_back(r);
      end
      r = blank_rec(KIND_FREQ);
      r.value = m_freq;
      recs.push_back(r);
    end else if (act && n != 0 && m_field >= 6 + 5 * n) begin
      for (int p = 0; p < n; p++) begin
        r = blank_rec(KIND_PROBE);
        r.idx = 2'(p);
        r.att = m_store[p].att;
        r.temp = m_store[p].temp;
        r.alarm = m_store[p].alarm;
        r.tmax = m_store[p].tmax;
        r.tmin = m_store[p].tmin;
        recs.push_back(r);
      end
      r = blank_rec(KIND_SUMMARY);
      r.att = m_blower;
      r.alarm = m_nalarm;
      r.fahr = m_fahr;
      recs.push_back(r);
    end
    if (recs.size() == 0) recs.push_back(blank_rec(KIND_ERROR));
    recs[recs.size() - 1].eor = 1;
    reset_message();
  endtask

  initial begin
    m_probes = 3'd4;
    reset_message();
    m_fahr = 0;
    m_nalarm = 0;
    m_blower = 0;
    foreach (m_store[i]) m_store[i] = '{default: '0};
  end

  always @(posedge clk) begin
    rec_t recs[$];
    rec_t e;
    if (rst_n && cfg_we) m_probes = cfg_wdata;
    if (rst_n && in_valid && in_ready) begin
      predict_records(in_action, in_character, in_last, recs);
      if (in_last && typed_err) begin
        e = blank_rec(KIND_ERROR);
        e.eor = 1;
        expected_q.push_back(e);
      end else foreach (recs[i]) expected_q.push_back(recs[i]);
    end
  end

  function automatic void check_field(string name, longint e, longint a);
    if (e != a) begin
      $error("%s: expected %0d, actual %0d", name, e, a);
      failed = 1;
    end
  endfunction

  always @(posedge clk) begin
    rec_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("record_kind: expected none, actual %0d", out_record_kind);
        failed = 1;
      end else begin
        e = expected_q.pop_front();
        check_field("record_kind", e.kind, out_record_kind);
        check_field("value", e.value, out_value);
        check_field("probe_index", e.idx, out_probe_index);
        check_field("attached", e.att, out_attached);
        check_field("temp_tenths", e.temp, out_temp_tenths);
        check_field("alarm", e.alarm, out_alarm);
        check_field("limit_high", e.tmax, out_limit_high);
        check_field("limit_low", e.tmin, out_limit_low);
        check_field("fahrenheit", e.fahr, out_fahrenheit);
        check_field("end_of_run", e.eor, out_end_of_run);
      end
    end
  end

  bit quiet = 0;

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver: random stalls, one long hold-off to back up the input side
  initial begin
    bit held;
    int g;
    held = 0;
    @(posedge clk iff rst_n);
    forever begin
      if (!held && hold_now) begin
        held = 1;
        out_ready <= 0;
        repeat (400) @(posedge clk);
      end
      g = pick_gap();
      if (g > 0) begin
        out_ready <= 0;
        repeat (g) @(posedge clk);
      end
      out_ready <= 1;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  end

  task automatic send_message(input logic act, input string msg);
    int g;
    quiet = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < msg.len(); i++) begin
      g = pick_gap();
      if (g > 0) begin
        in_valid <= 0;
        repeat (g) @(posedge clk);
      end
      in_valid <= 1;
      in_action <= act;
      in_character <= msg[i];
      in_last <= (i == msg.len() - 1);
      do @(posedge clk); while (!in_ready);
      items_sent++;
    end
    in_valid <= 0;
    @(posedge clk);
  endtask

  task automatic write_probe_count(input logic [2:0] v);
    wait (expected_q.size() == 0);
    repeat (6) @(posedge clk);
    cfg_we <= 1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  function automatic string rand_number();
    string s;
    int r;
    s = "";
    repeat ($urandom_range(0, 2)) s = {s, $sformatf("%c", ($urandom_range(0, 1) ?
      8'd32 : 8'($urandom_range(9, 13))))};
    r = $urandom_range(0, 9);
    if (r < 3) s = {s, "-"};
    else if (r == 3) s = {s, "+"};
    r = $urandom_range(0, 9);
    repeat ((r < 8) ? $urandom_range(1, 3) : $urandom_range(4, 6))
      s = {s, $sformatf("%0d", $urandom_range(0, 9))};
    if ($urandom_range(0, 5) == 0) s = {s, ".", $sformatf("%0d", $urandom_range(0, 9))};
    if ($urandom_range(0, 9) == 0) s = {s, $sformatf("%c", 8'($urandom_range(128, 255)))};
    return s;
  endfunction

  function automatic string rand_message(input logic act, input int probes);
    string s;
    int nf;
    nf = act ? 6 + 5 * probes : 6;
    s = "";
    if ($urandom_range(0, 4) == 0) nf = $urandom_range(1, nf);
    for (int f = 0; f < nf; f++) begin
      if (f > 0) s = {s, ","};
      if ($urandom_range(0, 9) == 0) s = {s, ","};
      if (!act && f == 1)
        repeat ($urandom_range(1, 8)) s = {s, $sformatf("%c", 8'($urandom_range(33, 126)))};
      else if (act && f >= 4 && (f - 4) % 5 == 0 && $urandom_range(0, 2) == 0) s = {s, "3"};
      else s = {s, rand_number()};
    end
    if ($urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 6)) s = {s, $sformatf("%c", 8'($urandom_range(1, 255)))};
    if ($urandom_range(0, 5) == 0) s = {s, ","};
    return s;
  endfunction

  // c<n>: write probe count; s/t: sync/state, predicted; S/T: error record typed in
  string directed [] = '{
    "sq,ABCDEFGHIJKLMNOPQRSTUVWXYZ012345678,255,-1,+32767,99999,",
    "S:a,b,,1",
    "S,",
    "t0,0, 1,\t-5,1,-12.7,1,800,-400,3,32767,0,99999,-99999,2,0,0,0,0,0,5,5,5,5,5,1,9",
    "T0,0,1",
    "c2",
    "t0,0,0,0,1,250,0,300,100,3,-1,1,2,1,0,x",
    "c3",
    "T1",
    "c0",
    "T1",
    "c7",
    "T1",
    "c4"
  };

  initial begin
    string s;
    logic [2:0] pc, cur_pc;
    logic act;
    int msg_no;
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    foreach (directed[i]) begin
      s = directed[i];
      if (s[0] == "c") write_probe_count(3'(s[1] - CHAR_ZERO));
      else begin
        typed_err = (s[0] == "S" || s[0] == "T");
        send_message(s[0] == "t" || s[0] == "T", s.substr(1, s.len() - 1));
        wait (expected_q.size() == 0);
        typed_err = 0;
      end
    end
    cur_pc = 3'd4;
    msg_no = 0;
    hold_now = 1;
    while (items_sent < 215) begin
      if (msg_no < 2) act = 1'b0;
      else begin
        pc = ($urandom_range(0, 1) == 0) ? 3'd2 : 3'd4;
        if (pc != cur_pc) begin
          write_probe_count(pc);
          cur_pc = pc;
        end
        act = 1'($urandom_range(0, 1));
      end
      s = rand_message(act, (cur_pc == 3'd2) ? 2 : 4);
      send_message(act, s);
      msg_no++;
    end
    wait (expected_q.size() == 0);
    repeat (20) @(posedge clk);
    if (!failed && expected_q.size() == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #4ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule
